FILE: hw/rtl/csf_pkg.sv
// ----------------------------------------------------------------------------
// csf_pkg
// Shared types and codes for the counting semaphore with waiter queue.
// ----------------------------------------------------------------------------
package csf_pkg;

   // field widths of the request and response transactions
   localparam int CMD_W    = 2;
   localparam int REQ_ID_W = 8;
   localparam int STATUS_W = 3;
   localparam int TOKEN_W  = 16;
   localparam int WAIT_W   = 5;

   // token counter limits
   localparam logic [TOKEN_W-1:0] TOKEN_MAX   = 16'hFFFF;
   localparam logic [TOKEN_W-1:0] TOKEN_RESET = 16'd1;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CANCEL  = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_ACQUIRED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_HANDOFF   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RAISED    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd6;
   localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd7;

   // one response transaction
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [REQ_ID_W-1:0] grant_id;
      logic [TOKEN_W-1:0]  token_count;
      logic [WAIT_W-1:0]   waiter_count;
   } result_type;

endpackage

FILE: hw/rtl/counting_semaphore_fifo_unit.sv
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_unit
// Counting semaphore with a FIFO of waiting requester IDs.
// ----------------------------------------------------------------------------
// Request channel (req_*): one command per transaction, acquire, release or
// cancel, with the requester ID. Response channel (rsp_*): exactly one
// transaction per command with status, granted ID, free tokens and number of
// waiters after the command. Both channels use valid/stall handshakes.
// CSR channel (csr_*): valid/ready write of the initial token count; a write
// also loads the live token count. Writes are taken only while idle and no
// request is offered.
// Sequencing: a command runs in a small sequencer around one pointer incrementer
// and one ID comparator. Acquire, release without waiters, cancel on an empty
// queue and unknown codes go from idle straight to the done state; a release
// handing off to a waiter first reads the queue memory in a handoff state; a
// cancel reads one queue entry per cycle in a scan state. The next request is
// taken as soon as the sequencer is idle, even while the previous response is still stalled.
// Reset: token count returns to 1, the queue empties; no clearing pass.
// A stalled response holds its payload; the next command's result waits in
// the sequencer until the response register frees.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_unit #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [csf_pkg::CMD_W-1:0]     req_command,
   input  logic [csf_pkg::REQ_ID_W-1:0]  req_requester_id,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [csf_pkg::STATUS_W-1:0]  rsp_status,
   output logic [csf_pkg::REQ_ID_W-1:0]  rsp_grant_id,
   output logic [csf_pkg::TOKEN_W-1:0]   rsp_token_count,
   output logic [csf_pkg::WAIT_W-1:0]    rsp_waiter_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [csf_pkg::TOKEN_W-1:0]   csr_initial_count
);
   import csf_pkg::*;

   logic       seq_idle;
   logic       seq_done;
   result_type seq_result;
   logic       start;
   logic       csr_we;
   logic       take;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   // handshakes; a CSR write never lands in the same cycle as a command
   assign req_stall = !seq_idle;
   assign start     = req_valid && !req_stall;
   assign csr_ready = seq_idle && !req_valid;
   assign csr_we    = csr_valid && csr_ready;
   assign take      = seq_done && (!rsp_valid_ff || !rsp_stall);

   csf_seq #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .cmd      (req_command),
      .req_id   (req_requester_id),
      .csr_we   (csr_we),
      .csr_data (csr_initial_count),
      .take     (take),
      .idle     (seq_idle),
      .done     (seq_done),
      .result   (seq_result)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= seq_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_grant_id     = rsp_ff.grant_id;
   assign rsp_token_count  = rsp_ff.token_count;
   assign rsp_waiter_count = rsp_ff.waiter_count;

endmodule

FILE: hw/rtl/csf_waitq.sv
// ----------------------------------------------------------------------------
// csf_waitq
// Waiter ID storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module csf_waitq #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/csf_seq.sv
// ----------------------------------------------------------------------------
// csf_seq
// Command sequencer: token counter, circular waiter queue pointers and the
// cancel scan that compacts the queue one entry per cycle.
// ----------------------------------------------------------------------------
module csf_seq #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [csf_pkg::CMD_W-1:0]     cmd,
   input  logic [csf_pkg::REQ_ID_W-1:0]  req_id,
   input  logic                          csr_we,
   input  logic [csf_pkg::TOKEN_W-1:0]   csr_data,
   input  logic                          take,
   output logic                          idle,
   output logic                          done,
   output csf_pkg::result_type           result
);
   import csf_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_HANDOFF = 2'd1;
   localparam logic [1:0] S_SCAN    = 2'd2;
   localparam logic [1:0] S_DONE    = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [TOKEN_W-1:0] tokens_ff, tokens_in;
   logic [CNT_W-1:0]   len_ff, len_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [PTR_W-1:0]   cur_addr_ff, cur_addr_in;
   logic [PTR_W-1:0]   prev_addr_ff, prev_addr_in;
   logic [CNT_W-1:0]   chk_ff, chk_in;
   logic               found_ff, found_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   result_type         res_ff, res_in;

   logic [ID_BITS-1:0] id_masked;
   logic [PTR_W-1:0]   step_src;
   logic [PTR_W-1:0]   step_out;
   logic               match;
   logic               last;

   logic               ram_we;
   logic [PTR_W-1:0]   ram_waddr;
   logic [ID_BITS-1:0] ram_wdata;
   logic               ram_re;
   logic [PTR_W-1:0]   ram_raddr;
   logic [ID_BITS-1:0] ram_rdata;

   csf_waitq #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (ID_BITS)
   ) u_waitq (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign id_masked = ID_BITS'(req_id);

   // shared pointer step unit: wrapping increment
   always_comb begin
      case (state_ff)
         S_HANDOFF: step_src = head_ff;
         S_SCAN:    step_src = cur_addr_ff;
         default:   step_src = tail_ff;
      endcase
      step_out = (step_src == PTR_LAST) ? '0 : step_src + PTR_W'(1);
   end

   // shared compare unit for the cancel scan
   assign match = !found_ff && (ram_rdata == id_ff);
   assign last  = (chk_ff == len_ff - CNT_W'(1));

   // next state
   always_comb begin
      state_in     = state_ff;
      tokens_in    = tokens_ff;
      len_in       = len_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cur_addr_in  = cur_addr_ff;
      prev_addr_in = prev_addr_ff;
      chk_in       = chk_ff;
      found_in     = found_ff;
      id_in        = id_ff;
      res_in       = res_ff;
      ram_we       = 1'b0;
      ram_waddr    = prev_addr_ff;
      ram_wdata    = ram_rdata;
      ram_re       = 1'b0;
      ram_raddr    = head_ff;

      case (state_ff)
         S_IDLE: begin
            if (csr_we) begin
               tokens_in = csr_data;
            end
            if (start) begin
               id_in           = id_masked;
               res_in.status   = ST_NOT_FOUND;
               res_in.grant_id = '0;
               state_in        = S_DONE;
               case (cmd)
                  CMD_ACQUIRE: begin
                     if (tokens_ff != '0) begin
                        tokens_in       = tokens_ff - TOKEN_W'(1);
                        res_in.status   = ST_ACQUIRED;
                        res_in.grant_id = REQ_ID_W'(id_masked);
                     end else if (len_ff != CNT_FULL) begin
                        ram_we        = 1'b1;
                        ram_waddr     = tail_ff;
                        ram_wdata     = id_masked;
                        tail_in       = step_out;
                        len_in        = len_ff + CNT_W'(1);
                        res_in.status = ST_QUEUED;
                     end else begin
                        res_in.status = ST_FULL;
                     end
                  end
                  CMD_RELEASE: begin
                     if (len_ff != '0) begin
                        ram_re   = 1'b1;
                        state_in = S_HANDOFF;
                     end else if (tokens_ff != TOKEN_MAX) begin
                        tokens_in     = tokens_ff + TOKEN_W'(1);
                        res_in.status = ST_RAISED;
                     end else begin
                        res_in.status = ST_SATURATED;
                     end
                  end
                  CMD_CANCEL: begin
                     if (len_ff != '0) begin
                        ram_re      = 1'b1;
                        cur_addr_in = head_ff;
                        chk_in      = '0;
                        found_in    = 1'b0;
                        state_in    = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         // oldest waiter's ID has arrived from the queue
         S_HANDOFF: begin
            res_in.status   = ST_HANDOFF;
            res_in.grant_id = REQ_ID_W'(ram_rdata);
            head_in         = step_out;
            len_in          = len_ff - CNT_W'(1);
            state_in        = S_DONE;
         end

         // compare one entry per cycle, shift later entries down once found
         S_SCAN: begin
            ram_we    = found_ff;
            ram_waddr = prev_addr_ff;
            ram_wdata = ram_rdata;
            if (last) begin
               if (found_ff || match) begin
                  len_in        = len_ff - CNT_W'(1);
                  tail_in       = cur_addr_ff;
                  res_in.status = ST_CANCELLED;
               end
               state_in = S_DONE;
            end else begin
               ram_re       = 1'b1;
               ram_raddr    = step_out;
               cur_addr_in  = step_out;
               prev_addr_in = cur_addr_ff;
               chk_in       = chk_ff + CNT_W'(1);
               found_in     = found_ff || match;
            end
         end

         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // counts in the response reflect the state after the command
      if (state_in == S_DONE && state_ff != S_DONE) begin
         res_in.token_count  = tokens_in;
         res_in.waiter_count = WAIT_W'(len_in);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         tokens_ff <= TOKEN_RESET;
         len_ff    <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         chk_ff    <= '0;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         tokens_ff <= tokens_in;
         len_ff    <= len_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         chk_ff    <= chk_in;
         found_ff  <= found_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_addr_ff  <= cur_addr_in;
      prev_addr_ff <= prev_addr_in;
      id_ff        <= id_in;
      res_ff       <= res_in;
   end

   assign idle   = (state_ff == S_IDLE);
   assign done   = (state_ff == S_DONE);
   assign result = res_ff;

endmodule

FILE: sim/tb_counting_semaphore_fifo_unit.sv
// ----------------------------------------------------------------------------
// tb_counting_semaphore_fifo_unit
// Self-checking bench for the counting semaphore with waiter queue.
// ----------------------------------------------------------------------------
// Commands are queued by the stimulus process and driven on the falling edge.
// At each rising edge every accepted command is run through a local model of
// the semaphore (token count plus waiter FIFO), and every response
// transaction is checked field by field against the oldest predicted one.
// A directed opening covers saturation, queue full, cancel hit and miss,
// handoff and the unused command code. Random batches under several initial
// counts and idling profiles follow.
// ----------------------------------------------------------------------------
module tb_counting_semaphore_fifo_unit;
   import csf_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int STALL_LIMIT = 4000;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [REQ_ID_W-1:0] requester_id;
   } request_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [CMD_W-1:0]      req_command;
   logic [REQ_ID_W-1:0]   req_requester_id;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [STATUS_W-1:0]   rsp_status;
   logic [REQ_ID_W-1:0]   rsp_grant_id;
   logic [TOKEN_W-1:0]    rsp_token_count;
   logic [WAIT_W-1:0]     rsp_waiter_count;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [TOKEN_W-1:0]    csr_initial_count;

   // local copy of the semaphore state
   logic [TOKEN_W-1:0]    free_tokens = TOKEN_RESET;
   logic [REQ_ID_W-1:0]   waiters[$];

   request_type           cmd_pending[$];
   result_type            replies_due[$];
   int                    commands_queued = 0;
   int                    replies_seen = 0;
   int                    count_writes = 0;
   int                    failures = 0;
   int                    quiet_cycles = 0;
   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;
   bit                    req_taken = 0;

   counting_semaphore_fifo_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_requester_id  (req_requester_id),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_grant_id      (rsp_grant_id),
      .rsp_token_count   (rsp_token_count),
      .rsp_waiter_count  (rsp_waiter_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_initial_count (csr_initial_count)
   );

   // clock and known input levels from time zero
   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_command       = CMD_ACQUIRE;
      req_requester_id  = '0;
      rsp_stall         = 1'b0;
      csr_valid         = 1'b0;
      csr_initial_count = '0;
      forever #2 clock = ~clock;
   end

   // one command through the semaphore: updates the local state
   task automatic apply_semaphore_command(input logic [CMD_W-1:0] cmd,
                                          input logic [REQ_ID_W-1:0] id,
                                          output result_type reply);
      int pos;
      reply        = '0;
      reply.status = ST_NOT_FOUND;
      pos          = -1;
      case (cmd)
         CMD_ACQUIRE: begin
            if (free_tokens != 0) begin
               free_tokens--;
               reply.status   = ST_ACQUIRED;
               reply.grant_id = id;
            end else if (waiters.size() < QUEUE_DEPTH) begin
               waiters = {waiters, id};
               reply.status = ST_QUEUED;
            end else begin
               reply.status = ST_FULL;
            end
         end
         CMD_RELEASE: begin
            if (waiters.size() != 0) begin
               reply.grant_id = waiters[0];
               waiters.delete(0);
               reply.status   = ST_HANDOFF;
            end else if (free_tokens != TOKEN_MAX) begin
               free_tokens++;
               reply.status = ST_RAISED;
            end else begin
               reply.status = ST_SATURATED;
            end
         end
         CMD_CANCEL: begin
            // oldest matching waiter goes
            for (int i = 0; i < waiters.size(); i++) begin
               if (pos < 0 && waiters[i] == id) pos = i;
            end
            if (pos >= 0) begin
               waiters.delete(pos);
               reply.status = ST_CANCELLED;
            end
         end
         default: ;
      endcase
      reply.token_count  = free_tokens;
      reply.waiter_count = WAIT_W'(waiters.size());
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         failures++;
      end
   endtask

   // request driver: a stalled transaction holds, otherwise maybe take the next
   always @(negedge clock) begin : request_driver
      request_type next_req;
      if (!req_valid || req_taken) begin
         if (cmd_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_req = cmd_pending[0];
            cmd_pending.delete(0);
            req_valid        <= 1'b1;
            req_command      <= next_req.command;
            req_requester_id <= next_req.requester_id;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // monitor: predict on accepted commands, check accepted responses
   always @(posedge clock) begin : semaphore_monitor
      result_type want;
      result_type got;
      bit         rsp_taken;
      bit         csr_taken;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && !req_stall;
         rsp_taken = rsp_valid && !rsp_stall;
         csr_taken = csr_valid && csr_ready;
         if (csr_taken) begin
            // a write also reloads the live count; waiters stay
            free_tokens = csr_initial_count;
            count_writes++;
         end
         if (req_taken) begin
            apply_semaphore_command(req_command, req_requester_id, want);
            replies_due = {replies_due, want};
         end
         if (rsp_taken) begin
            got.status       = rsp_status;
            got.grant_id     = rsp_grant_id;
            got.token_count  = rsp_token_count;
            got.waiter_count = rsp_waiter_count;
            if (replies_due.size() == 0) begin
               $display("%0t: response with none outstanding, expected none, actual %p",
                        $time, got);
               failures++;
            end else begin
               want = replies_due[0];
               replies_due.delete(0);
               check_field("status", int'(want.status), int'(got.status));
               check_field("grant_id", int'(want.grant_id), int'(got.grant_id));
               check_field("token_count", int'(want.token_count), int'(got.token_count));
               check_field("waiter_count", int'(want.waiter_count),
                           int'(got.waiter_count));
            end
            replies_seen++;
         end
         // watchdog on cycles with no transaction at all
         if (req_taken || rsp_taken || csr_taken) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("counting_semaphore_fifo_unit test failed");
            $finish;
         end
      end
   end

   task automatic add_request(input logic [CMD_W-1:0] cmd, input logic [REQ_ID_W-1:0] id);
      request_type r;
      r.command      = cmd;
      r.requester_id = id;
      cmd_pending = {cmd_pending, r};
      commands_queued++;
   endtask

   // sender holds off until every outstanding response is back
   task automatic wait_for_drain();
      wait (replies_seen == commands_queued);
   endtask

   task automatic write_initial_count(input logic [TOKEN_W-1:0] value);
      int target;
      target = count_writes + 1;
      @(negedge clock);
      csr_valid         <= 1'b1;
      csr_initial_count <= value;
      wait (count_writes == target);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // random commands; IDs mostly from a small pool so cancels find waiters
   task automatic queue_random_batch(input int count, input int acquire_pct,
                                     input int release_pct);
      logic [REQ_ID_W-1:0] id_pool[6];
      logic [REQ_ID_W-1:0] id;
      logic [CMD_W-1:0]    cmd;
      int                  pick;
      foreach (id_pool[i]) id_pool[i] = REQ_ID_W'($urandom_range(255));
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < acquire_pct) cmd = CMD_ACQUIRE;
         else if (pick < acquire_pct + release_pct) cmd = CMD_RELEASE;
         else if (pick < 97) cmd = CMD_CANCEL;
         else cmd = CMD_UNUSED;
         if ($urandom_range(99) < 80) id = id_pool[$urandom_range(5)];
         else id = REQ_ID_W'($urandom_range(255));
         add_request(cmd, id);
      end
   endtask

   // stimulus
   initial begin : stimulus
      logic [REQ_ID_W-1:0] fill_ids[16];
      logic [TOKEN_W-1:0]  settings[12];
      logic [TOKEN_W-1:0]  setting;
      fill_ids = '{8'h00, 8'hFF, 8'h07, 8'h5A, 8'h07, 8'h01, 8'h02, 8'h04,
                   8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'hFE, 8'hA5, 8'h3C};
      settings = '{16'd0, 16'hFFFF, 16'd1, 16'd2, 16'hFFFD, 16'd0,
                   16'd3, 16'hFFFF, 16'd0, 16'd1, 16'd5, 16'hFFFE};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 25;
      recv_idle_pct = 45;

      // reset count of one: first acquire succeeds
      add_request(CMD_ACQUIRE, 8'h3C);
      wait_for_drain();

      // count at maximum: saturation, raise back to maximum, empty queue cases
      write_initial_count(TOKEN_MAX);
      add_request(CMD_RELEASE, 8'h00);
      add_request(CMD_ACQUIRE, 8'hFF);
      add_request(CMD_RELEASE, 8'hFF);
      add_request(CMD_RELEASE, 8'h11);
      add_request(CMD_CANCEL, 8'h00);
      add_request(CMD_UNUSED, 8'hA5);
      wait_for_drain();

      // no tokens: fill the queue, overflow, cancel hit and miss, handoff
      write_initial_count(16'd0);
      foreach (fill_ids[i]) add_request(CMD_ACQUIRE, fill_ids[i]);
      add_request(CMD_ACQUIRE, 8'h99);
      add_request(CMD_CANCEL, 8'h07);
      add_request(CMD_CANCEL, 8'h33);
      add_request(CMD_RELEASE, 8'h00);
      wait_for_drain();

      // random batches over three idling profiles
      for (int b = 0; b < 12; b++) begin
         if (b == 4) begin
            send_idle_pct = 45;
            recv_idle_pct = 25;
         end else if (b == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (b == 5) setting = TOKEN_W'($urandom_range(65535));
         else if (b == 10) setting = TOKEN_W'($urandom_range(20));
         else setting = settings[b];
         write_initial_count(setting);
         case (b % 3)
            0: begin
               queue_random_batch(65, 55, 25);
               if (b % 4 == 1) wait_for_drain();
               queue_random_batch(65, 55, 25);
            end
            1: begin
               queue_random_batch(65, 25, 55);
               if (b % 4 == 1) wait_for_drain();
               queue_random_batch(65, 25, 55);
            end
            default: begin
               queue_random_batch(65, 40, 40);
               if (b % 4 == 1) wait_for_drain();
               queue_random_batch(65, 40, 40);
            end
         endcase
         wait_for_drain();
      end

      // let any stray response show up before the verdict
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("counting_semaphore_fifo_unit test passed");
      end else begin
         $display("counting_semaphore_fifo_unit test failed");
      end
      $finish;
   end

endmodule
